FILE: rtl/core/exchange_power_pid_regulator_defines.svh
// Assertion helper macros
`ifndef EXCHANGE_POWER_PID_REGULATOR_DEFINES_SVH
`define EXCHANGE_POWER_PID_REGULATOR_DEFINES_SVH
`define EPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPR_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/core/epr_pkg.sv
`default_nettype none
package epr_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned QueueDepth = 2;
    localparam logic [CfgIdxW-1:0] REG_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TARGET = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GP     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GI     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GD     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MINSTEP = 3'd5;
    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = -48'sh7FFF_FFFF_FFFF - 48'sd1;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] heat_coef;
        logic        [30:0] cell_volume;
        logic signed [31:0] outside_temp;
        logic signed [31:0] cell_temp;
        logic        [30:0] step_size;
        logic               last_cell;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_ACC, ST_ERR, ST_DIVE, ST_PI1, ST_PI2,
        ST_D1, ST_DIVD, ST_SUM, ST_OUT
    } t_state;

    // saturate a signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return MAX32;
        else if (v < -96'sd2147483648) return MIN32;
        else return v[31:0];
    endfunction

    // truncating Q16 shift of a signed product, toward zero
    function automatic logic signed [95:0] shq(input logic signed [95:0] v);
        logic [95:0] m;
        m = v[95] ? 96'(-v) : 96'(v);
        m = m >> 16;
        return v[95] ? -$signed(m) : $signed(m);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/epr_div.sv
`default_nettype none
// restoring divider: 64-bit magnitude numerator by 31-bit divisor, 1 bit/cycle
module epr_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [30:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quo
);
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [30:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [31:0] w_trial;
    assign w_trial = {r_rem[30:0], r_q[63]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
endmodule
`default_nettype wire

FILE: rtl/core/epr_front.sv
`default_nettype none
// input queue
module epr_front #(
    parameter int unsigned DEPTH = epr_pkg::QueueDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire epr_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_pop,
    output epr_pkg::t_item      o_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    epr_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic w_push, w_pop;
    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push = i_valid && o_ready;
    assign w_pop  = i_pop && o_valid;
    assign o_item = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/epr_back.sv
`default_nettype none
module epr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_pop,
    input  wire epr_pkg::t_item i_item,
    input  wire logic           i_enable,
    input  wire logic [30:0]    i_target,
    input  wire logic [31:0]    i_gp,
    input  wire logic [31:0]    i_gi,
    input  wire logic [31:0]    i_gd,
    input  wire logic [30:0]    i_minstep,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [47:0]         o_power,
    output logic [31:0]         o_offset
);
    epr_pkg::t_state r_st, n_st;
    epr_pkg::t_item  r_it;
    logic signed [47:0] r_acc, r_total;
    logic signed [31:0] r_off, r_prev, r_e, r_p, r_ie, r_i, r_d;
    logic signed [33:0] r_diff;
    logic [62:0] r_a;
    logic [95:0] r_m;
    logic        r_neg;
    logic signed [95:0] r_t;
    logic div_start, div_done;
    logic [63:0] div_num, div_quo;
    logic [30:0] div_den;
    logic signed [48:0] w_num;
    logic signed [95:0] w_dn;
    logic [33:0] w_dmag;

    epr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quo(div_quo));

    assign w_num = 49'(r_total) - 49'($signed({1'b0, i_target}));
    assign w_dn  = 96'(r_e) - 96'(r_prev);
    assign w_dmag = $unsigned(r_diff[33] ? -r_diff : r_diff);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            epr_pkg::ST_IDLE: if (i_valid) n_st = epr_pkg::ST_MUL1;
            epr_pkg::ST_MUL1: n_st = epr_pkg::ST_MUL2;
            epr_pkg::ST_MUL2: n_st = epr_pkg::ST_MUL3;
            epr_pkg::ST_MUL3: n_st = epr_pkg::ST_ACC;
            epr_pkg::ST_ACC:  n_st = !r_it.last_cell ? epr_pkg::ST_IDLE :
                                     (i_enable ? epr_pkg::ST_ERR : epr_pkg::ST_OUT);
            epr_pkg::ST_ERR:  n_st = (i_target == '0) ? epr_pkg::ST_PI1 : epr_pkg::ST_DIVE;
            epr_pkg::ST_DIVE: if (div_done) n_st = epr_pkg::ST_PI1;
            epr_pkg::ST_PI1:  n_st = (r_it.step_size >= i_minstep) ? epr_pkg::ST_PI2 :
                                     epr_pkg::ST_OUT;
            epr_pkg::ST_PI2:  n_st = epr_pkg::ST_D1;
            epr_pkg::ST_D1:   n_st = (r_it.step_size == '0) ? epr_pkg::ST_SUM :
                                     epr_pkg::ST_DIVD;
            epr_pkg::ST_DIVD: if (div_done) n_st = epr_pkg::ST_SUM;
            epr_pkg::ST_SUM:  n_st = epr_pkg::ST_OUT;
            epr_pkg::ST_OUT:  if (i_ready) n_st = epr_pkg::ST_IDLE;
            default:          n_st = epr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_st == epr_pkg::ST_IDLE) && i_valid;
        o_valid = (r_st == epr_pkg::ST_OUT);
        div_start = 1'b0;
        div_num = '0;
        div_den = i_target;
        if (r_st == epr_pkg::ST_ERR) begin
            div_start = (i_target != '0);
            div_num = 64'(w_num[48] ? 49'(-w_num) : w_num) << 16;
        end else if (r_st == epr_pkg::ST_D1) begin
            div_start = (r_it.step_size != '0);
            div_num = 64'(r_t[95] ? 96'(-r_t) : r_t) << 16;
            div_den = r_it.step_size;
        end
    end

    assign o_power = r_total;
    assign o_offset = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= epr_pkg::ST_IDLE;
            r_acc <= '0;
            r_off <= '0;
            r_prev <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                epr_pkg::ST_IDLE: begin
                    r_it <= i_item;
                    r_diff <= 34'(r_off) + 34'(i_item.outside_temp) - 34'(i_item.cell_temp);
                end
                epr_pkg::ST_MUL1: begin
                    r_a <= 63'($unsigned(r_it.heat_coef[31] ? -r_it.heat_coef
                                                            : r_it.heat_coef))
                           * 63'(r_it.cell_volume);
                    r_neg <= r_it.heat_coef[31] ^ r_diff[33];
                end
                // coef*volume times |diff| in two partial products
                epr_pkg::ST_MUL2: begin
                    r_m <= 96'(r_a[31:0]) * 96'(w_dmag);
                end
                epr_pkg::ST_MUL3: begin
                    r_m <= r_m + ((96'(r_a[62:32]) * 96'(w_dmag)) << 32);
                end
                epr_pkg::ST_ACC: begin
                    logic [63:0] m;
                    logic signed [49:0] s, t;
                    m = (r_m[95:32] > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : r_m[95:32];
                    t = r_neg ? -$signed(50'(m)) : $signed(50'(m));
                    if (t > 50'(epr_pkg::MAX48)) t = 50'(epr_pkg::MAX48);
                    s = 50'(r_acc) + t;
                    if (s > 50'(epr_pkg::MAX48)) s = 50'(epr_pkg::MAX48);
                    else if (s < 50'(epr_pkg::MIN48)) s = 50'(epr_pkg::MIN48);
                    if (r_it.last_cell) begin
                        r_total <= s[47:0];
                        r_acc <= '0;
                    end else begin
                        r_acc <= s[47:0];
                    end
                end
                epr_pkg::ST_ERR: begin
                    r_e <= (w_num > 0) ? epr_pkg::MAX32 :
                           ((w_num < 0) ? epr_pkg::MIN32 : '0);
                end
                epr_pkg::ST_DIVE: if (div_done) begin
                    logic [63:0] q;
                    q = (div_quo > 64'h1_0000_0000) ? 64'h1_0000_0000 : div_quo;
                    r_e <= epr_pkg::sat32(w_num[48] ? -$signed(96'(q)) : $signed(96'(q)));
                end
                epr_pkg::ST_PI1: begin
                    r_p  <= epr_pkg::sat32(epr_pkg::shq(96'($signed(i_gp)) * 96'(r_e)));
                    r_ie <= epr_pkg::sat32(epr_pkg::shq(96'($signed(i_gi)) * 96'(r_e)));
                    if (r_it.step_size < i_minstep) r_prev <= r_e;
                end
                epr_pkg::ST_PI2: begin
                    r_i <= epr_pkg::sat32(epr_pkg::shq(96'($signed({1'b0, r_it.step_size}))
                                                       * 96'(r_ie)));
                    r_t <= epr_pkg::shq(96'($signed(i_gd)) * w_dn);
                end
                epr_pkg::ST_D1: begin
                    r_d <= (r_t > 0) ? epr_pkg::MAX32 : ((r_t < 0) ? epr_pkg::MIN32 : '0);
                end
                epr_pkg::ST_DIVD: if (div_done) begin
                    logic [63:0] q;
                    q = (div_quo > 64'h1_0000_0000) ? 64'h1_0000_0000 : div_quo;
                    r_d <= epr_pkg::sat32(r_t[95] ? -$signed(96'(q)) : $signed(96'(q)));
                end
                epr_pkg::ST_SUM: begin
                    r_off <= epr_pkg::sat32(96'(r_off) + 96'(r_p) + 96'(r_i) + 96'(r_d));
                    r_prev <= r_e;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/exchange_power_pid_regulator.sv
// channel  | dir | payload
// s_axis   | in  | tdata: heat_coef, cell_volume, outside_temp, cell_temp, step_size; tlast
// m_axis   | out | tdata: total_power, temp_offset
// cfg      | in  | index 3 bits, data 32 bits
// A cell passes through the back end as pop, magnitude product, two partial products, add.
// With regulation on, the last cell adds up to two divisions (error, derivative); each is
// skipped when its divisor is zero, the derivative one also when step_size is under min step.
// Reset (i_rst_n low, synchronous) clears accumulator, offset and previous error.
// A two-entry queue parts input acceptance from the back end; results wait for tready.
`default_nettype none
module exchange_power_pid_regulator #(
    parameter int unsigned QUEUE_DEPTH = epr_pkg::QueueDepth
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // heat_coef[31:0], cell_volume[62:32], outside_temp[94:63], cell_temp[126:95],
    // step_size[157:127], zero pad
    input  wire logic [159:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // total_power[47:0], temp_offset[79:48]
    output logic [79:0]       m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [epr_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    epr_pkg::t_item w_in, w_q;
    logic w_qv, w_pop;
    logic r_en;
    logic [30:0] r_tgt, r_min;
    logic [31:0] r_gp, r_gi, r_gd;
    logic [47:0] w_pw;
    logic [31:0] w_of;

    assign w_in.heat_coef    = s_axis_tdata[31:0];
    assign w_in.cell_volume  = s_axis_tdata[62:32];
    assign w_in.outside_temp = s_axis_tdata[94:63];
    assign w_in.cell_temp    = s_axis_tdata[126:95];
    assign w_in.step_size    = s_axis_tdata[157:127];
    assign w_in.last_cell    = s_axis_tlast;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tdata = {w_of, w_pw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_tgt <= 31'd65536;
            r_gp <= '0;
            r_gi <= '0;
            r_gd <= '0;
            r_min <= 31'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                epr_pkg::REG_ENABLE:  r_en <= i_cfg_data[0];
                epr_pkg::REG_TARGET:  r_tgt <= i_cfg_data[30:0];
                epr_pkg::REG_GP:      r_gp <= i_cfg_data;
                epr_pkg::REG_GI:      r_gi <= i_cfg_data;
                epr_pkg::REG_GD:      r_gd <= i_cfg_data;
                epr_pkg::REG_MINSTEP: r_min <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    epr_front #(.DEPTH(QUEUE_DEPTH)) u_front (.i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_valid(w_qv), .i_pop(w_pop), .o_item(w_q));

    epr_back u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_pop(w_pop),
        .i_item(w_q), .i_enable(r_en), .i_target(r_tgt), .i_gp(r_gp), .i_gi(r_gi),
        .i_gd(r_gd), .i_minstep(r_min), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_power(w_pw), .o_offset(w_of));
endmodule
`default_nettype wire

FILE: rtl/core/epr_checker.sv
`default_nettype none
`include "exchange_power_pid_regulator_defines.svh"
module epr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata
);
    `EPR_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `EPR_ASSERT(a_out_gap, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid, "result repeated")
    `EPR_ASSERT_RST(a_reset, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "reset state")
endmodule
bind exchange_power_pid_regulator epr_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 300;
    localparam longint SAT48_HI = 64'sd140737488355327;
    localparam longint SAT48_LO = -64'sd140737488355328;
    localparam longint SAT32_HI = 64'sd2147483647;
    localparam longint SAT32_LO = -64'sd2147483648;
    localparam logic [epr_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [epr_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [47:0] total_power;
        logic signed [31:0] temp_offset;
    } t_power_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [epr_pkg::CfgIdxW-1:0] i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    // regulator model state
    logic        mdl_enable;
    logic [30:0] mdl_target;
    int          mdl_gain_p, mdl_gain_i, mdl_gain_d;
    logic [30:0] mdl_min_step;
    longint      mdl_power_acc, mdl_offset, mdl_prev_error;

    t_power_result expected_power[$];
    bit     failed = 1'b0;
    int     idle_pct = 16;
    longint cycle_count = 0;

    exchange_power_pid_regulator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[exchange_power_pid_regulator] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_power_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_power.size() == 0) begin
                $error("unexpected result transaction: %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                exp_r = expected_power.pop_front();
                if (m_axis_tdata[47:0] !== exp_r.total_power) begin
                    $error("total_power: expected %0d, got %0d", exp_r.total_power,
                           $signed(m_axis_tdata[47:0]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[79:48] !== exp_r.temp_offset) begin
                    $error("temp_offset: expected %0d, got %0d", exp_r.temp_offset,
                           $signed(m_axis_tdata[79:48]));
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [127:0] mag128(longint a);
        logic [127:0] m;
        m = a < 0 ? 128'(-a) : 128'(a);
        return m;
    endfunction

    function automatic longint with_sign(logic [127:0] m, bit neg);
        longint v;
        v = longint'(m[63:0]);
        return neg ? -v : v;
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        logic [127:0] m;
        m = mag128(a) * mag128(b);
        m = m >> 16;
        return with_sign(m, (a < 0) != (b < 0));
    endfunction

    function automatic longint div_q16_sat32(longint num, longint den);
        logic [127:0] q;
        if (den == 0)
            return num > 0 ? SAT32_HI : (num < 0 ? SAT32_LO : 0);
        q = (mag128(num) << 16) / mag128(den);
        if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
        return clamp(with_sign(q, num < 0), SAT32_LO, SAT32_HI);
    endfunction

    function automatic longint cell_power(longint coef, longint vol, longint diff);
        logic [127:0] m;
        m = mag128(coef) * mag128(vol);
        m = m * mag128(diff);
        m = m >> 32;
        if (m > 128'h8000_0000_0000) m = 128'h8000_0000_0000;
        return clamp(with_sign(m, (coef < 0) != (diff < 0)), SAT48_LO, SAT48_HI);
    endfunction

    task automatic update_power_model(epr_pkg::t_item it);
        longint diff, total, err, p, ie, i, d;
        t_power_result r;
        diff = mdl_offset + longint'(it.outside_temp) - longint'(it.cell_temp);
        mdl_power_acc = clamp(mdl_power_acc + cell_power(longint'(it.heat_coef),
                              longint'({1'b0, it.cell_volume}), diff), SAT48_LO, SAT48_HI);
        if (it.last_cell) begin
            total = mdl_power_acc;
            if (mdl_enable) begin
                err = div_q16_sat32(total - longint'(mdl_target), longint'(mdl_target));
                if (it.step_size >= mdl_min_step) begin
                    p = clamp(mul_q16(mdl_gain_p, err), SAT32_LO, SAT32_HI);
                    ie = clamp(mul_q16(mdl_gain_i, err), SAT32_LO, SAT32_HI);
                    i = clamp(mul_q16(longint'(it.step_size), ie), SAT32_LO, SAT32_HI);
                    d = div_q16_sat32(mul_q16(mdl_gain_d, err - mdl_prev_error),
                                      longint'(it.step_size));
                    mdl_offset = clamp(mdl_offset + p + i + d, SAT32_LO, SAT32_HI);
                end
                mdl_prev_error = err;
            end
            r.total_power = total[47:0];
            r.temp_offset = mdl_offset[31:0];
            expected_power.push_back(r);
            mdl_power_acc = 0;
        end
    endtask

    task automatic send_cell(epr_pkg::t_item it);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, it.step_size, it.cell_temp, it.outside_temp,
                         it.cell_volume, it.heat_coef};
        s_axis_tlast <= it.last_cell;
        do @(posedge i_clk); while (!s_axis_tready);
        update_power_model(it);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_power.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [epr_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            epr_pkg::REG_ENABLE:  mdl_enable = val[0];
            epr_pkg::REG_TARGET:  mdl_target = val[30:0];
            epr_pkg::REG_GP:      mdl_gain_p = val;
            epr_pkg::REG_GI:      mdl_gain_i = val;
            epr_pkg::REG_GD:      mdl_gain_d = val;
            epr_pkg::REG_MINSTEP: mdl_min_step = val[30:0];
            default: ;
        endcase
    endtask

    task automatic write_all(bit en, logic [31:0] tgt, logic [31:0] gp, logic [31:0] gi,
                             logic [31:0] gd, logic [31:0] ms);
        write_reg(epr_pkg::REG_ENABLE, {31'd0, en});
        write_reg(epr_pkg::REG_TARGET, tgt);
        write_reg(epr_pkg::REG_GP, gp);
        write_reg(epr_pkg::REG_GI, gi);
        write_reg(epr_pkg::REG_GD, gd);
        write_reg(epr_pkg::REG_MINSTEP, ms);
    endtask

    function automatic epr_pkg::t_item mk_cell(logic [31:0] c, logic [30:0] v, logic [31:0] o,
                                               logic [31:0] t, logic [30:0] s, bit l);
        epr_pkg::t_item it;
        it.heat_coef = c; it.cell_volume = v; it.outside_temp = o;
        it.cell_temp = t; it.step_size = s; it.last_cell = l;
        return it;
    endfunction

    function automatic logic [31:0] rand_word(bit modest);
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return modest ? 32'($signed($urandom_range(0, 32'h00FF_FFFF)) -
                                        32'sh0080_0000) : $urandom;
        endcase
    endfunction

    function automatic epr_pkg::t_item rand_cell();
        epr_pkg::t_item it;
        it.heat_coef = rand_word(1);
        it.cell_volume = 31'(rand_word(1));
        if ($urandom_range(0, 2) != 0) it.cell_volume = 31'($urandom_range(0, 32'h0004_0000));
        it.outside_temp = rand_word(1);
        it.cell_temp = rand_word(1);
        it.step_size = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(0, 32'h0003_0000));
        it.last_cell = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    task automatic test_reset_defaults();
        send_cell(mk_cell(32'h0001_0000, 31'h0001_0000, 32'h0002_0000, 32'h0, 31'h1, 1));
        send_cell(mk_cell(32'hFFFF_0000, 31'h0002_0000, 32'h0, 32'h0005_0000, 31'h1, 1));
        wait_idle();
    endtask

    task automatic test_saturation_extremes();
        send_cell(mk_cell(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 0));
        send_cell(mk_cell(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          31'h7FFF_FFFF, 1));
        send_cell(mk_cell(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 1));
        send_cell(mk_cell(32'h0, 31'h0, 32'h0, 32'h0, 31'h0, 1));
        send_cell(mk_cell(32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0, 0));
        send_cell(mk_cell(32'h0003_0000, 31'h0001_0000, 32'h0001_0000, 32'h0, 31'h1, 1));
        wait_idle();
    endtask

    task automatic test_regulation_cases();
        write_all(1, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000, 32'h0001_0000);
        send_cell(mk_cell(32'h0002_0000, 31'h0001_0000, 32'h0003_0000, 32'h0, 31'h0001_0000, 1));
        send_cell(mk_cell(32'h0001_0000, 31'h0001_0000, 32'h0001_0000, 32'h0, 31'h0000_8000, 1));
        send_cell(mk_cell(32'h0001_0000, 31'h0001_0000, 32'h0, 32'h0004_0000, 31'h0002_0000, 1));
        wait_idle();
        // zero target, zero step with min step zero
        write_all(1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_cell(mk_cell(32'h0001_0000, 31'h0001_0000, 32'h0001_0000, 32'h0, 31'h0, 1));
        send_cell(mk_cell(32'h0, 31'h0, 32'h0, 32'h0, 31'h0, 1));
        send_cell(mk_cell(32'hFFFF_0000, 31'h0001_0000, 32'h0001_0000, 32'h0, 31'h0, 1));
        send_cell(mk_cell(32'h0001_0000, 31'h0001_0000, 32'h0, 32'h0, 31'h7FFF_FFFF, 1));
        wait_idle();
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0);
        write_all(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cell(mk_cell(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          31'h7FFF_FFFF, 1));
        send_cell(mk_cell(32'h0001_0000, 31'h0001_0000, 32'h0, 32'h0, 31'h7FFF_FFFE, 1));
        wait_idle();
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    task automatic test_random_updates();
        logic [31:0] tgt, ms;
        for (int phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 4))
                0: tgt = 32'h0;
                1: tgt = 32'h1;
                2: tgt = 32'h7FFF_FFFF;
                3: tgt = $urandom;
                default: tgt = $urandom_range(1, 32'h0100_0000);
            endcase
            case ($urandom_range(0, 3))
                0: ms = 32'h0;
                1: ms = 32'h7FFF_FFFF;
                default: ms = $urandom_range(0, 32'h0002_0000);
            endcase
            write_all(phase % 5 != 0, tgt, rand_gain(), rand_gain(), rand_gain(), ms);
            idle_pct = (phase == 3) ? 0 : 16;
            for (int n = 0; n < 140; n++) send_cell(rand_cell());
            send_cell(mk_cell($urandom, 31'($urandom), $urandom, $urandom, 31'($urandom), 1));
            wait_idle();
        end
    endtask

    initial begin
        mdl_enable = 0; mdl_target = 31'd65536; mdl_gain_p = 0; mdl_gain_i = 0;
        mdl_gain_d = 0; mdl_min_step = 31'd1;
        mdl_power_acc = 0; mdl_offset = 0; mdl_prev_error = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_saturation_extremes();
        test_regulation_cases();
        test_random_updates();
        wait_idle();
        if (!failed && expected_power.size() == 0) begin
            $display("[exchange_power_pid_regulator] OK");
        end else begin
            $display("[exchange_power_pid_regulator] ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/epr_pkg.sv
rtl/core/epr_div.sv
rtl/core/epr_front.sv
rtl/core/epr_back.sv
rtl/core/exchange_power_pid_regulator.sv
rtl/core/epr_checker.sv
sim/testbench.sv
